// ===== rtl/core/b32kd_pkg.sv =====
`default_nettype none
package b32kd_pkg;

    // Seed length limits, in characters
    localparam int MAX_SEED_CHARS = 63;
    localparam int MIN_SEED_CHARS = 16;
    localparam int COUNT_SAT      = MAX_SEED_CHARS + 1;
    localparam int CHAR_CNT_W     = $clog2(COUNT_SAT + 1);

    // Fixed field widths
    localparam int CHAR_W   = 8;
    localparam int SYM_W    = 5;
    localparam int ACC_W    = 12;
    localparam int HELD_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;

    // Symbol alphabet boundaries
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_2 = 8'h32;
    localparam logic [CHAR_W-1:0] CH_DIGIT_7 = 8'h37;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;
    localparam logic [SYM_W-1:0]  DIGIT_BASE = 5'd26;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_LENGTH  = 3'd1,
        ST_BAD_REMAIN  = 3'd2,
        ST_BAD_CHAR    = 3'd3,
        ST_BAD_PADDING = 3'd4
    } t_status;

    typedef struct packed {
        logic                byte_valid;
        logic [BYTE_W-1:0]   key_byte;
        logic [INDEX_W-1:0]  byte_index;
        logic                done_res;
        t_status             status;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/b32kd_if.sv =====
`default_nettype none
interface b32kd_in_if;
    logic                       valid;
    logic                       ready;
    logic [b32kd_pkg::CHAR_W-1:0] char_code;
    logic                       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface b32kd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          byte_valid;
    logic [b32kd_pkg::BYTE_W-1:0]   key_byte;
    logic [b32kd_pkg::INDEX_W-1:0]  byte_index;
    logic                          done_res;
    logic [b32kd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output byte_valid, output key_byte, output byte_index,
                    output done_res, output status, input ready);
    modport sink   (input valid, input byte_valid, input key_byte, input byte_index,
                    input done_res, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/base32_key_decoder.sv =====
// Base32 key decoder: unpadded, case-insensitive RFC 4648 Base32, one
// seed character per transaction on i_in (char_code, last flag).
// Every input transaction yields exactly one result transaction on o_out:
// byte_valid/key_byte/byte_index when the character completed a key byte,
// and done_res/status on the result of the final character. Bytes are
// provisional; discard the key unless the final status is ok.
// Each result is registered before it is presented. Throughput: one
// character per cycle while i_in.ready is high, set by the single decode
// step (shift, merge, byte extract) between the input handshake and the
// result register. A result register plus a skid register decouple the
// sides, so a character is taken even while one finished result waits.
// Receiver stall: results collect in the skid register; i_in.ready drops
// only while both result slots are full.
// Reset (i_rst_n low, synchronous): clear the accumulator, counters, the
// bad-character flag and both result slots. All but the result slots
// clear after every final character, so the next seed can follow at once.
`default_nettype none
module base32_key_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    b32kd_in_if.sink    i_in,
    b32kd_out_if.source o_out
);
    import b32kd_pkg::*;

    // decode state
    logic [ACC_W-1:0]      r_acc,        n_acc;
    logic [HELD_W-1:0]     r_held,       n_held;
    logic [CHAR_CNT_W-1:0] r_char_cnt,   n_char_cnt;
    logic [INDEX_W-1:0]    r_out_cnt,    n_out_cnt;
    logic                  r_bad_seen,   n_bad_seen;

    // result slots
    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;

    logic                  in_accept;
    logic                  out_take;
    logic [CHAR_W-1:0]     upper_code;
    logic                  is_alpha;
    logic                  is_digit;
    logic                  sym_legal;
    logic [SYM_W-1:0]      sym_val;
    logic [ACC_W-1:0]      shifted_acc;
    logic [HELD_W-1:0]     held_plus;
    logic [HELD_W-1:0]     held_left;
    logic                  emit;
    logic [ACC_W-1:0]      acc_upd;
    logic [HELD_W-1:0]     held_upd;
    logic [CHAR_CNT_W-1:0] cnt_upd;
    logic                  bad_upd;
    logic [2:0]            cnt_rem;
    t_result               result;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_take  = o_out.valid && o_out.ready;

    // Fold lower case onto upper case, then map the symbol
    always_comb begin
        upper_code = i_in.char_code;
        if (i_in.char_code >= CH_LOWER_A && i_in.char_code <= CH_LOWER_Z) begin
            upper_code = i_in.char_code - CASE_DELTA;
        end
        is_alpha  = (upper_code >= CH_UPPER_A) && (upper_code <= CH_UPPER_Z);
        is_digit  = (upper_code >= CH_DIGIT_2) && (upper_code <= CH_DIGIT_7);
        sym_legal = is_alpha || is_digit;
        if (is_alpha) begin
            sym_val = SYM_W'(upper_code - CH_UPPER_A);
        end else if (is_digit) begin
            sym_val = SYM_W'(upper_code - CH_DIGIT_2) + DIGIT_BASE;
        end else begin
            sym_val = '0;
        end
    end

    // Append five bits; pull out a byte once eight or more are held
    always_comb begin
        shifted_acc = {r_acc[ACC_W-SYM_W-1:0], sym_val};
        held_plus   = r_held + HELD_W'(SYM_W);
        emit        = sym_legal && (held_plus >= HELD_W'(BYTE_W));
        held_left   = held_plus - HELD_W'(BYTE_W);

        acc_upd  = r_acc;
        held_upd = r_held;
        bad_upd  = r_bad_seen;
        if (!sym_legal) begin
            bad_upd = 1'b1;
        end else if (emit) begin
            acc_upd  = shifted_acc & ((ACC_W'(1) << held_left) - ACC_W'(1));
            held_upd = held_left;
        end else begin
            acc_upd  = shifted_acc;
            held_upd = held_plus;
        end

        cnt_upd = r_char_cnt;
        if (r_char_cnt < CHAR_CNT_W'(COUNT_SAT)) begin
            cnt_upd = r_char_cnt + CHAR_CNT_W'(1);
        end
        cnt_rem = cnt_upd[2:0];

        result            = '0;
        result.byte_valid = emit;
        if (emit) begin
            result.key_byte   = BYTE_W'(shifted_acc >> held_left);
            result.byte_index = r_out_cnt;
        end
        result.done_res = i_in.last;
        result.status   = ST_OK;
        if (i_in.last) begin
            priority if (cnt_upd < CHAR_CNT_W'(MIN_SEED_CHARS)
                         || cnt_upd > CHAR_CNT_W'(MAX_SEED_CHARS)) begin
                result.status = ST_BAD_LENGTH;
            end else if (cnt_rem == 3'd1 || cnt_rem == 3'd3 || cnt_rem == 3'd6) begin
                result.status = ST_BAD_REMAIN;
            end else if (bad_upd) begin
                result.status = ST_BAD_CHAR;
            end else if (acc_upd != '0) begin
                result.status = ST_BAD_PADDING;
            end else begin
                result.status = ST_OK;
            end
        end
    end

    // Next state: advance on each accepted character, clear after the last
    always_comb begin
        n_acc      = r_acc;
        n_held     = r_held;
        n_char_cnt = r_char_cnt;
        n_out_cnt  = r_out_cnt;
        n_bad_seen = r_bad_seen;
        if (in_accept) begin
            if (i_in.last) begin
                n_acc      = '0;
                n_held     = '0;
                n_char_cnt = '0;
                n_out_cnt  = '0;
                n_bad_seen = 1'b0;
            end else begin
                n_acc      = acc_upd;
                n_held     = held_upd;
                n_char_cnt = cnt_upd;
                n_out_cnt  = emit ? r_out_cnt + INDEX_W'(1) : r_out_cnt;
                n_bad_seen = bad_upd;
            end
        end
    end

    // Result register with skid slot; hold order, drop a slot once taken
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (in_accept) begin
            if (!r_out_valid || (out_take && !r_skid_valid)) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_held       <= '0;
            r_char_cnt   <= '0;
            r_out_cnt    <= '0;
            r_bad_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_held       <= n_held;
            r_char_cnt   <= n_char_cnt;
            r_out_cnt    <= n_out_cnt;
            r_bad_seen   <= n_bad_seen;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign i_in.ready       = !r_skid_valid;
    assign o_out.valid      = r_out_valid;
    assign o_out.byte_valid = r_out.byte_valid;
    assign o_out.key_byte   = r_out.key_byte;
    assign o_out.byte_index = r_out.byte_index;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.status     = r_out.status;

endmodule
`default_nettype wire
